// File: sv/rbfta_pkg.sv
// Shared types, command codes and register indexes of the force and torque accumulator.
package rbfta_pkg;

  // Width of every input vector and arm component
  localparam int IN_BITS = 32;

  typedef logic signed [IN_BITS-1:0] in_word_t;
  typedef logic [2:0] cmd_t;

  // Operation codes carried by the cmd field
  localparam cmd_t CMD_FORCE       = 3'd0;
  localparam cmd_t CMD_IMPULSE     = 3'd1;
  localparam cmd_t CMD_TORQUE      = 3'd2;
  localparam cmd_t CMD_SPIN_TORQUE = 3'd3;
  localparam cmd_t CMD_CLEAR       = 3'd4;

  // Configuration register indexes
  localparam logic REG_FREEZE_TRANSLATION = 1'b0;
  localparam logic REG_FREEZE_ROTATION    = 1'b1;

endpackage

// File: sv/rbfta_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read-first output.
module rbfta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/rbfta_cross.sv
// Two-stage arm x vector unit: full products, then difference, floor shift and clip.
module rbfta_cross #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  rbfta_pkg::in_word_t         arm [3],
  input  rbfta_pkg::in_word_t         vec [3],
  output logic [2:0][WORD_BITS-1:0]   term,
  output logic                        sat
);
  import rbfta_pkg::*;

  localparam int PROD_BITS = 2 * IN_BITS;
  localparam int DIFF_BITS = PROD_BITS + 1;
  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_MIN = ~W_MAX;

  logic signed [PROD_BITS-1:0] pa_r [3];
  logic signed [PROD_BITS-1:0] pb_r [3];
  logic signed [DIFF_BITS-1:0] diff [3];
  logic signed [DIFF_BITS-1:0] shd  [3];
  logic [DIFF_BITS-WORD_BITS:0] hi  [3];
  logic [2:0][WORD_BITS-1:0]   term_nxt;
  logic [2:0]                  csat;
  logic [2:0][WORD_BITS-1:0]   term_r;
  logic                        sat_r;

  // Register the six full products
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= arm[1] * vec[2];
      pb_r[0] <= arm[2] * vec[1];
      pa_r[1] <= arm[2] * vec[0];
      pb_r[1] <= arm[0] * vec[2];
      pa_r[2] <= arm[0] * vec[1];
      pb_r[2] <= arm[1] * vec[0];
    end
  end

  // Subtract, shift toward minus infinity, clip to the word range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_BITS'(pa_r[i]) - DIFF_BITS'(pb_r[i]);
      shd[i]  = diff[i] >>> FRAC_BITS;
      hi[i]   = shd[i][DIFF_BITS-1:WORD_BITS-1];
      csat[i] = !((&hi[i]) || !(|hi[i]));
      if (csat[i]) begin
        term_nxt[i] = shd[i][DIFF_BITS-1] ? W_MIN : W_MAX;
      end else begin
        term_nxt[i] = shd[i][WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      sat_r  <= |csat;
    end
  end

  assign term = term_r;
  assign sat  = sat_r;

endmodule

// File: sv/rigid_body_force_torque_accumulator.sv
// Top level of the rigid body force and torque accumulator.
//
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   in_cmd, in_vec_{x,y,z}, in_arm_{x,y,z}
//  out_     output     out_valid / out_stall out_lin_{x,y,z}, out_rot_{x,y,z}, out_saturated
//  config   APB        psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
//  One item per cycle while the output is not stalled; each item passes these stages:
//  input register, product register, cross term register beside the sum memory read,
//  then the output register as the sum is written back with forwarding.
//  Reset clears control and the per-entry valid bits at once; no clearing pass is run.
//  A stalled output holds the whole pipeline; in_stall follows out_stall in that case.
module rigid_body_force_torque_accumulator #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rbfta_pkg::cmd_t       in_cmd,
  input  rbfta_pkg::in_word_t   in_vec_x,
  input  rbfta_pkg::in_word_t   in_vec_y,
  input  rbfta_pkg::in_word_t   in_vec_z,
  input  rbfta_pkg::in_word_t   in_arm_x,
  input  rbfta_pkg::in_word_t   in_arm_y,
  input  rbfta_pkg::in_word_t   in_arm_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_lin_x,
  output logic signed [31:0]    out_lin_y,
  output logic signed [31:0]    out_lin_z,
  output logic signed [31:0]    out_rot_x,
  output logic signed [31:0]    out_rot_y,
  output logic signed [31:0]    out_rot_z,
  output logic                  out_saturated,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rbfta_pkg::*;

  localparam int ENTRY_W  = 6 * WORD_BITS;
  localparam int CLIP_LSB = (WORD_BITS < IN_BITS) ? WORD_BITS - 1 : IN_BITS - 1;
  localparam in_word_t CLIP_MIN = in_word_t'(-(64'sd1 <<< CLIP_LSB));
  localparam in_word_t CLIP_MAX = ~CLIP_MIN;
  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_MIN = ~W_MAX;

  // Configuration
  logic freeze_t_r, freeze_r_r;
  logic cfg_wr;

  // Pipeline control
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_valid_r;

  // Input stage
  in_word_t raw     [6];
  in_word_t clipped [6];
  logic [5:0] clip_hit;
  logic [IN_BITS-CLIP_LSB-1:0] clip_hi [6];

  cmd_t     s1_cmd_r, s2_cmd_r, s3_cmd_r;
  in_word_t s1_v_r [3];
  in_word_t s1_a_r [3];
  in_word_t s2_v_r [3];
  in_word_t s3_v_r [3];
  logic     s1_isat_r, s2_isat_r, s3_isat_r;
  logic     s2_addr, s3_addr_r;

  // Cross product unit outputs, aligned with stage 3
  logic [2:0][WORD_BITS-1:0] term;
  logic                      term_sat;

  // Sum memory and forwarding
  logic [ENTRY_W-1:0]        ram_rdata;
  logic                      ram_we;
  logic [1:0]                vld_r;
  logic                      fwd_vld_r;
  logic                      fwd_addr_r;
  logic [5:0][WORD_BITS-1:0] fwd_data_r;
  logic [5:0][WORD_BITS-1:0] base;
  logic [5:0][WORD_BITS-1:0] entry_new;
  logic                      do_clear;

  // Stage 3 arithmetic
  logic                      is_lin, is_rot, lin_upd, rot_upd;
  logic [WORD_BITS-1:0]      vw      [3];
  logic [WORD_BITS-1:0]      rot_add [3];
  logic [WORD_BITS:0]        lin_res [3];
  logic [WORD_BITS:0]        rot_res [3];
  logic [2:0]                lin_ovf, rot_ovf;
  logic [WORD_BITS-1:0]      res_lin [3];
  logic [WORD_BITS-1:0]      res_rot [3];
  logic                      res_sat;

  logic [31:0] out_lin_r [3];
  logic [31:0] out_rot_r [3];
  logic        out_sat_r;

  function automatic logic [WORD_BITS:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                 input logic [WORD_BITS-1:0] b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_add = {1'b1, (s[WORD_BITS] ? W_MIN : W_MAX)};
    end else begin
      sat_add = {1'b0, s[WORD_BITS-1:0]};
    end
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {31'd0, (paddr[2] == REG_FREEZE_ROTATION) ? freeze_r_r : freeze_t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freeze_t_r <= 1'b0;
      freeze_r_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FREEZE_TRANSLATION) begin
        freeze_t_r <= pwdata[0];
      end else begin
        freeze_r_r <= pwdata[0];
      end
    end
  end

  // Advance the whole pipeline unless a finished result is held
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  // Clip inputs to the word range
  assign raw[0] = in_vec_x;
  assign raw[1] = in_vec_y;
  assign raw[2] = in_vec_z;
  assign raw[3] = in_arm_x;
  assign raw[4] = in_arm_y;
  assign raw[5] = in_arm_z;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      clip_hi[i]  = raw[i][IN_BITS-1:CLIP_LSB];
      clip_hit[i] = !((&clip_hi[i]) || !(|clip_hi[i]));
      if (clip_hit[i]) begin
        clipped[i] = raw[i][IN_BITS-1] ? CLIP_MIN : CLIP_MAX;
      end else begin
        clipped[i] = raw[i];
      end
    end
  end

  // Valid bits of the pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  // Payload of the pipeline stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= in_cmd;
      s1_isat_r <= |clip_hit;
      for (int i = 0; i < 3; i++) begin
        s1_v_r[i] <= clipped[i];
        s1_a_r[i] <= clipped[3 + i];
        s2_v_r[i] <= s1_v_r[i];
        s3_v_r[i] <= s2_v_r[i];
      end
      s2_cmd_r  <= s1_cmd_r;
      s2_isat_r <= s1_isat_r;
      s3_cmd_r  <= s2_cmd_r;
      s3_isat_r <= s2_isat_r;
      s3_addr_r <= s2_addr;
    end
  end

  rbfta_cross #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cross (
    .clk  (clk),
    .en   (adv),
    .arm  (s1_a_r),
    .vec  (s1_v_r),
    .term (term),
    .sat  (term_sat)
  );

  // Entry 0 holds force and torque, entry 1 impulse and spin torque
  assign s2_addr = (s2_cmd_r == CMD_IMPULSE) || (s2_cmd_r == CMD_SPIN_TORQUE);

  rbfta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s3_addr_r),
    .wr_data (entry_new),
    .rd_en   (adv),
    .rd_addr (s2_addr),
    .rd_data (ram_rdata)
  );

  // Pick the current sums: last write, memory, or zero for a cleared entry
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s3_addr_r)) begin
      base = fwd_data_r;
    end else if (vld_r[s3_addr_r]) begin
      base = ram_rdata;
    end else begin
      base = '0;
    end
  end

  // Saturating updates of the linear and rotational sums
  always_comb begin
    is_lin  = (s3_cmd_r == CMD_FORCE) || (s3_cmd_r == CMD_IMPULSE);
    is_rot  = (s3_cmd_r == CMD_TORQUE) || (s3_cmd_r == CMD_SPIN_TORQUE);
    lin_upd = is_lin && !freeze_t_r;
    rot_upd = (is_lin || is_rot) && !freeze_r_r;
    for (int i = 0; i < 3; i++) begin
      vw[i]         = WORD_BITS'(s3_v_r[i]);
      rot_add[i]    = is_lin ? term[i] : vw[i];
      lin_res[i]    = sat_add(base[i], vw[i]);
      rot_res[i]    = sat_add(base[3 + i], rot_add[i]);
      lin_ovf[i]    = lin_res[i][WORD_BITS];
      rot_ovf[i]    = rot_res[i][WORD_BITS];
      entry_new[i]     = lin_upd ? lin_res[i][WORD_BITS-1:0] : base[i];
      entry_new[3 + i] = rot_upd ? rot_res[i][WORD_BITS-1:0] : base[3 + i];
    end
  end

  // Select the reported sums and the clip flag
  always_comb begin
    case (s3_cmd_r)
      CMD_FORCE, CMD_IMPULSE, CMD_TORQUE, CMD_SPIN_TORQUE: begin
        for (int i = 0; i < 3; i++) begin
          res_lin[i] = entry_new[i];
          res_rot[i] = entry_new[3 + i];
        end
        res_sat = s3_isat_r || (lin_upd && (|lin_ovf))
                  || (rot_upd && ((|rot_ovf) || (is_lin && term_sat)));
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 3; i++) begin
          res_lin[i] = '0;
          res_rot[i] = '0;
        end
        res_sat = 1'b0;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          res_lin[i] = base[i];
          res_rot[i] = base[3 + i];
        end
        res_sat = 1'b0;
      end
    endcase
  end

  assign ram_we   = adv && s3_vld_r && (is_lin || is_rot);
  assign do_clear = adv && s3_vld_r && (s3_cmd_r == CMD_CLEAR);

  // Track written entries and the last write for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
    end else if (do_clear) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      fwd_vld_r <= ram_we;
      if (ram_we) begin
        vld_r[s3_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= s3_addr_r;
      fwd_data_r <= entry_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        out_lin_r[i] <= 32'($signed(res_lin[i]));
        out_rot_r[i] <= 32'($signed(res_rot[i]));
      end
      out_sat_r <= res_sat;
    end
  end

  assign out_lin_x     = out_lin_r[0];
  assign out_lin_y     = out_lin_r[1];
  assign out_lin_z     = out_lin_r[2];
  assign out_rot_x     = out_rot_r[0];
  assign out_rot_y     = out_rot_r[1];
  assign out_rot_z     = out_rot_r[2];
  assign out_saturated = out_sat_r;

  // A forwarded entry is always marked as written
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> vld_r[fwd_addr_r])
    else $error("forwarding register holds an entry not marked valid");

  // A clear drops every entry
  a_clear_vld: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (vld_r == 2'b00) && !fwd_vld_r)
    else $error("clear left a valid entry");

  // A clear reports zero sums without a clip
  a_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (out_lin_x == 32'sd0) && (out_rot_z == 32'sd0) && !out_saturated)
    else $error("clear result not zero");

  // Input holds only while a result waits
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // No memory write while the pipeline holds
  a_we_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (adv && !do_clear))
    else $error("sum memory written during a hold");

endmodule
